### design/pva_pkg.sv
// Shared types and constants for the polar vector add unit.
// Holds the item and result structs, datapath widths and the arctangent table.
// No dependencies.
package pva_pkg;

    typedef struct packed {
        logic [15:0] first_length;
        logic [15:0] first_direction;
        logic [15:0] second_length;
        logic [15:0] second_direction;
    } item_t;

    typedef struct packed {
        logic [16:0]        sum_length;
        logic signed [15:0] sum_direction;
    } result_t;

    localparam int STEPS      = 17;
    localparam int RW         = 34;   // rotation x/y width
    localparam int ZR         = 25;   // rotation angle width
    localparam int PW         = 65;   // gain product width
    localparam int VW         = 36;   // vectoring x/y width
    localparam int ZV         = 26;   // vectoring angle width
    localparam int ROT_DEPTH  = 19;   // prelude, 17 iterations, gain multiply
    localparam int VEC_DEPTH  = 21;   // prelude, 17 iterations, three length stages

    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int MAX_LENGTH   = 131070;

    localparam logic [29:0] INV_GAIN = 30'd652032874;

    localparam int ATAN [STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57
    };

endpackage

### design/pva_rotate.sv
// Rotation-mode CORDIC pipeline: polar vector to gain-corrected rectangular products.
// Uses pva_pkg.
module pva_rotate (
    input  logic                          clk,
    input  logic                          en,
    input  logic [15:0]                   length,
    input  logic [15:0]                   direction,
    output logic signed [pva_pkg::PW-1:0] px,
    output logic signed [pva_pkg::PW-1:0] py
);
    import pva_pkg::*;

    logic signed [RW-1:0] x_reg [0:STEPS];
    logic signed [RW-1:0] y_reg [0:STEPS];
    logic signed [ZR-1:0] z_reg [0:STEPS];
    logic signed [RW-1:0] x_next;
    logic signed [ZR-1:0] z_next;
    logic [15:0]          dq;
    int                   zi;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;

    // fold direction into one turn, then into the right half plane
    always_comb
    begin
        dq = direction;
        if (int'(direction) >= FULL_TURN)
        begin
            dq = direction - 16'(FULL_TURN);
        end
        zi     = int'(dq);
        x_next = $signed(RW'({length, 14'b0}));
        if (zi <= QUARTER_TURN)
        begin
            zi = zi;
        end
        else if (zi < FULL_TURN - QUARTER_TURN)
        begin
            zi     = zi - HALF_TURN;
            x_next = -x_next;
        end
        else
        begin
            zi = zi - FULL_TURN;
        end
        z_next = ZR'(zi * 512);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZR'(ATAN[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZR'(ATAN[i]);
                end
            end
        end
    end

    // remove the CORDIC gain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= PW'(x_reg[STEPS]) * PW'($signed({1'b0, INV_GAIN}));
            py_reg <= PW'(y_reg[STEPS]) * PW'($signed({1'b0, INV_GAIN}));
        end
    end

    assign px = px_reg;
    assign py = py_reg;

endmodule

### design/pva_vector.sv
// Vectoring-mode CORDIC pipeline: resultant components to length and direction.
// Uses pva_pkg.
module pva_vector (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [pva_pkg::VW-1:0] x_in,
    input  logic signed [pva_pkg::VW-1:0] y_in,
    input  logic                          zero_in,
    output pva_pkg::result_t              res
);
    import pva_pkg::*;

    localparam logic signed [ZV-1:0] Z180 = ZV'(HALF_TURN * 512);

    logic signed [VW-1:0] x_reg [0:STEPS];
    logic signed [VW-1:0] y_reg [0:STEPS];
    logic signed [ZV-1:0] z_reg [0:STEPS];
    logic                 zero_reg [0:STEPS];

    logic signed [49:0]   ph_reg;
    logic [46:0]          pl_reg;
    logic signed [ZV-1:0] z1_reg;
    logic                 zero1_reg;
    logic signed [39:0]   t_reg;
    logic signed [ZV-1:0] z2_reg;
    logic                 zero2_reg;
    result_t              res_reg;

    logic signed [67:0]   acc;
    logic signed [39:0]   lr;
    logic signed [ZV-1:0] dr;
    result_t              res_next;

    // flip left half plane onto the right, start angle at +/-180
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= zero_in;
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? Z180 : -Z180;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZV'(ATAN[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZV'(ATAN[i]);
                end
            end
        end
    end

    // gain correction split into two partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg    <= 50'($signed(x_reg[STEPS][VW-1:17])) * 50'($signed({1'b0, INV_GAIN}));
            pl_reg    <= 47'(x_reg[STEPS][16:0]) * 47'(INV_GAIN);
            z1_reg    <= z_reg[STEPS];
            zero1_reg <= zero_reg[STEPS];
        end
    end

    always_comb
    begin
        acc = (68'(ph_reg) <<< 17) + $signed(68'(pl_reg)) + 68'sd536870912;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= 40'(acc >>> 30);
            z2_reg    <= z1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // round to output formats and clamp
    always_comb
    begin
        lr = (t_reg + 40'sd8192) >>> 14;
        dr = (z2_reg + ZV'(256)) >>> 9;
        if (lr < 0)
        begin
            res_next.sum_length = '0;
        end
        else if (lr > 40'(MAX_LENGTH))
        begin
            res_next.sum_length = 17'(MAX_LENGTH);
        end
        else
        begin
            res_next.sum_length = lr[16:0];
        end
        if (dr > ZV'(HALF_TURN))
        begin
            res_next.sum_direction = 16'(HALF_TURN);
        end
        else if (dr < -ZV'(HALF_TURN))
        begin
            res_next.sum_direction = -16'(HALF_TURN);
        end
        else
        begin
            res_next.sum_direction = dr[15:0];
        end
        if (zero2_reg)
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### design/polar_vector_add_unit.sv
// Polar vector add unit: sums two polar vectors, pipelined from item acceptance to result valid.
// Throughput one item per cycle; every register stage advances together
// unless a finished result is held by result_stall.
// Reset clears only the valid bits of the pipeline; data registers carry no reset.
// Depends on pva_pkg, pva_rotate and pva_vector.
module polar_vector_add_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pva_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pva_pkg::result_t result
);
    import pva_pkg::*;

    // rotate stages, one sum stage, vectoring stages
    localparam int DEPTH = ROT_DEPTH + 1 + VEC_DEPTH;

    logic                 en;
    logic [DEPTH-1:0]     valid_reg;
    logic [DEPTH-1:0]     valid_next;

    logic signed [PW-1:0] px1;
    logic signed [PW-1:0] py1;
    logic signed [PW-1:0] px2;
    logic signed [PW-1:0] py2;
    logic signed [PW-1:0] rx1;
    logic signed [PW-1:0] ry1;
    logic signed [PW-1:0] rx2;
    logic signed [PW-1:0] ry2;
    logic signed [VW-1:0] xs_reg;
    logic signed [VW-1:0] ys_reg;
    logic                 zero_reg;
    logic signed [VW-1:0] xs_next;
    logic signed [VW-1:0] ys_next;

    // Advance the whole pipeline unless the output item is held.
    assign en         = !(valid_reg[DEPTH-1] && result_stall);
    assign item_stall = !en;

    // Valid bits travel alongside the data.
    assign valid_next = {valid_reg[DEPTH-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Each vector gets its own rotation pipeline.
    pva_rotate u_rot_first (
        .clk       (clk),
        .en        (en),
        .length    (item.first_length),
        .direction (item.first_direction),
        .px        (px1),
        .py        (py1)
    );

    pva_rotate u_rot_second (
        .clk       (clk),
        .en        (en),
        .length    (item.second_length),
        .direction (item.second_direction),
        .px        (px2),
        .py        (py2)
    );

    // Round the gain-corrected products to Q22.14 and add components.
    always_comb
    begin
        rx1     = (px1 + 65'sd536870912) >>> 30;
        ry1     = (py1 + 65'sd536870912) >>> 30;
        rx2     = (px2 + 65'sd536870912) >>> 30;
        ry2     = (py2 + 65'sd536870912) >>> 30;
        xs_next = VW'(rx1) + VW'(rx2);
        ys_next = VW'(ry1) + VW'(ry2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg   <= xs_next;
            ys_reg   <= ys_next;
            zero_reg <= (xs_next == '0) && (ys_next == '0);
        end
    end

    // Length and direction of the resultant; its last register is the output.
    pva_vector u_vec (
        .clk     (clk),
        .en      (en),
        .x_in    (xs_reg),
        .y_in    (ys_reg),
        .zero_in (zero_reg),
        .res     (result)
    );

    assign result_valid = valid_reg[DEPTH-1];

endmodule
